FILE: sv/occ_pkg.sv
// ============================================================================
// occ_pkg
// Shared types and constants for the outline path stream with conic to
// cubic conversion.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package occ_pkg;

    // Default coordinate width in font units.
    localparam int COORD_WIDTH_DEF = 16;

    // Number of coordinates carried in one beat on either side.
    localparam int NUM_COORDS = 6;

    // Width of the kind and operation codes.
    localparam int KIND_W = 3;
    localparam int OP_W   = 2;

    // Outline command kinds on the input side.
    typedef enum logic [KIND_W-1:0] {
        KIND_BEGIN = 3'd0,
        KIND_MOVE  = 3'd1,
        KIND_LINE  = 3'd2,
        KIND_CONIC = 3'd3,
        KIND_CUBIC = 3'd4,
        KIND_END   = 3'd5
    } t_kind;

    // Path operations on the output side.
    typedef enum logic [OP_W-1:0] {
        OP_MOVE  = 2'd0,
        OP_LINE  = 2'd1,
        OP_CURVE = 2'd2,
        OP_CLOSE = 2'd3
    } t_op;

endpackage : occ_pkg

`default_nettype wire

FILE: sv/occ_two_thirds.sv
// ============================================================================
// occ_two_thirds
// Moves a point two thirds of the way towards a control point, rounding the
// offset to the nearest integer with halves away from zero.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module occ_two_thirds #(
    parameter int COORD_WIDTH = occ_pkg::COORD_WIDTH_DEF
) (
    input  wire logic signed [COORD_WIDTH-1:0] i_point,
    input  wire logic signed [COORD_WIDTH-1:0] i_ctrl,
    output logic signed [COORD_WIDTH-1:0]      o_result
);

    localparam int CW     = COORD_WIDTH;
    localparam int PROD_W = 2 * CW + 2;

    // Reciprocal of three scaled by 2^(CW+2), rounded up. With a dividend
    // below 2^(CW+1) the truncated product equals the exact floor quotient.
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << (COORD_WIDTH + 2)) + 64'd2) / 64'd3;
    localparam logic [CW:0] RECIP = RECIP_FULL[CW:0];

    logic [CW:0]     diff;
    logic            neg;
    logic [CW:0]     mag;
    logic [CW:0]     dividend;
    logic [PROD_W-1:0] prod;
    logic [CW-1:0]   quot;
    logic [CW-1:0]   offset;

    // Difference kept one bit wider so that it never overflows.
    assign diff     = {i_ctrl[CW-1], i_ctrl} - {i_point[CW-1], i_point};
    assign neg      = diff[CW];
    assign mag      = neg ? (~diff + (CW+1)'(1)) : diff;
    // Twice the magnitude plus one; the magnitude always fits in CW bits.
    assign dividend = {mag[CW-1:0], 1'b1};
    assign prod     = PROD_W'(dividend) * PROD_W'(RECIP);
    assign quot     = prod[PROD_W-1:CW+2];
    assign offset   = neg ? (~quot + CW'(1)) : quot;
    assign o_result = i_point + offset;

endmodule : occ_two_thirds

`default_nettype wire

FILE: sv/outline_conic_to_cubic_path_stream.sv
// ============================================================================
// outline_conic_to_cubic_path_stream
// Turns glyph outline commands into path operations, converting conic
// segments into cubic curves and closing open contours on move and end.
// ============================================================================
// Path: a command is captured in the input register, decoded
// combinationally, and its beats are written into the result register.
// Throughput: one command per cycle while the master side takes beats; a move
// that closes an open contour needs two result beats, one beat a cycle.
// Reset (synchronous, active low) empties both registers, clears the last
// end point to the origin and marks the contour closed.
`timescale 1ns / 1ps
`default_nettype none

module outline_conic_to_cubic_path_stream #(
    parameter int COORD_WIDTH = occ_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // Command side.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y, then zero pad
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  wire logic [occ_pkg::KIND_W-1:0] s_axis_tuser,

    // Path side.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, then zero pad
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // op
    output logic [occ_pkg::OP_W-1:0]    m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int CW     = COORD_WIDTH;
    localparam int PTS_W  = occ_pkg::NUM_COORDS * CW;
    localparam int DATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // Input register: holds one command until all of its beats have been
    // written into the result register.
    logic                          r_in_valid;
    logic [occ_pkg::KIND_W-1:0]    r_in_kind;
    logic [PTS_W-1:0]              r_in_pts;

    // Outline state: last end point and whether a contour is open.
    logic signed [CW-1:0]          r_prev_x;
    logic signed [CW-1:0]          r_prev_y;
    logic                          r_open;
    // Set once the close beat of a two-beat move has been issued.
    logic                          r_phase;

    // Result register.
    logic                          r_out_valid;
    occ_pkg::t_op                  r_out_op;
    logic                          r_out_last;
    logic [PTS_W-1:0]              r_out_pts;

    // ------------------------------------------------------------------
    // Field unpacking
    // ------------------------------------------------------------------
    logic signed [CW-1:0] in_ax;
    logic signed [CW-1:0] in_ay;
    logic signed [CW-1:0] in_ex;
    logic signed [CW-1:0] in_ey;

    assign in_ax = r_in_pts[0*CW +: CW];
    assign in_ay = r_in_pts[1*CW +: CW];
    assign in_ex = r_in_pts[4*CW +: CW];
    assign in_ey = r_in_pts[5*CW +: CW];

    // ------------------------------------------------------------------
    // Conic to cubic conversion: the first control is pulled from the
    // previous end point, the second from the new end point, each two
    // thirds of the way towards the conic control.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] c1_x;
    logic signed [CW-1:0] c1_y;
    logic signed [CW-1:0] c2_x;
    logic signed [CW-1:0] c2_y;

    occ_two_thirds #(.COORD_WIDTH(CW)) u_c1_x (
        .i_point (r_prev_x),
        .i_ctrl  (in_ax),
        .o_result(c1_x)
    );

    occ_two_thirds #(.COORD_WIDTH(CW)) u_c1_y (
        .i_point (r_prev_y),
        .i_ctrl  (in_ay),
        .o_result(c1_y)
    );

    occ_two_thirds #(.COORD_WIDTH(CW)) u_c2_x (
        .i_point (in_ex),
        .i_ctrl  (in_ax),
        .o_result(c2_x)
    );

    occ_two_thirds #(.COORD_WIDTH(CW)) u_c2_y (
        .i_point (in_ey),
        .i_ctrl  (in_ay),
        .o_result(c2_y)
    );

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    // For the command in the input register this works out the beat to
    // issue now (if any), whether it is the command's final beat, and the
    // outline state left behind once the command retires.
    logic                  emit;
    logic                  emit_last;
    occ_pkg::t_op          emit_op;
    logic [PTS_W-1:0]      emit_pts;
    logic signed [CW-1:0]  n_prev_x;
    logic signed [CW-1:0]  n_prev_y;
    logic                  n_open;

    always_comb begin
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_op   = occ_pkg::OP_MOVE;
        emit_pts  = '0;
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_open    = r_open;
        unique case (occ_pkg::t_kind'(r_in_kind))
            occ_pkg::KIND_BEGIN: begin
                n_open = 1'b0;
            end
            occ_pkg::KIND_MOVE: begin
                // An open contour is closed by a separate beat ahead of the move.
                emit = 1'b1;
                if (r_open && !r_phase) begin
                    emit_op = occ_pkg::OP_CLOSE;
                end else begin
                    emit_op   = occ_pkg::OP_MOVE;
                    emit_last = 1'b1;
                    emit_pts  = PTS_W'({in_ey, in_ex});
                end
                n_prev_x = in_ex;
                n_prev_y = in_ey;
                n_open   = 1'b1;
            end
            occ_pkg::KIND_LINE: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_op   = occ_pkg::OP_LINE;
                emit_pts  = PTS_W'({in_ey, in_ex});
                n_prev_x  = in_ex;
                n_prev_y  = in_ey;
                n_open    = 1'b1;
            end
            occ_pkg::KIND_CONIC: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_op   = occ_pkg::OP_CURVE;
                emit_pts  = {in_ey, in_ex, c2_y, c2_x, c1_y, c1_x};
                n_prev_x  = in_ex;
                n_prev_y  = in_ey;
            end
            occ_pkg::KIND_CUBIC: begin
                // The input coordinate order already matches the curve layout.
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_op   = occ_pkg::OP_CURVE;
                emit_pts  = r_in_pts;
                n_prev_x  = in_ex;
                n_prev_y  = in_ey;
            end
            occ_pkg::KIND_END: begin
                if (r_open) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    emit_op   = occ_pkg::OP_CLOSE;
                end
                n_open = 1'b0;
            end
            default: begin
                // Unused kind codes retire silently with no state change.
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    // The result register can take a beat when it is empty or being
    // drained this cycle. A command retires when it has nothing to issue
    // or when its final beat is written.
    logic out_free;
    logic load;
    logic consume;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign load          = r_in_valid && emit && out_free;
    assign consume       = r_in_valid && (!emit || (out_free && emit_last));
    assign s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_open      <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (consume) begin
                r_phase  <= 1'b0;
                r_prev_x <= n_prev_x;
                r_prev_y <= n_prev_y;
                r_open   <= n_open;
            end else if (load) begin
                r_phase <= 1'b1;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= s_axis_tuser;
            r_in_pts  <= s_axis_tdata[PTS_W-1:0];
        end
        if (load) begin
            r_out_op   <= emit_op;
            r_out_last <= emit_last;
            r_out_pts  <= emit_pts;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_op;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = DATA_W'(r_out_pts);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The second beat of a move is only pending while a move that closed
    // an open contour is still held.
    a_phase_is_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_in_valid && r_in_kind == occ_pkg::KIND_MOVE && r_open))
        else $error("pending second beat without an open-contour move");

    // A close beat carries no coordinates.
    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == occ_pkg::OP_CLOSE) |-> (r_out_pts == '0))
        else $error("close beat with non-zero coordinates");

    // Only the close ahead of a move may be a non-final beat.
    a_nonlast_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == occ_pkg::OP_CLOSE))
        else $error("non-final beat that is not a close");

    // An end command always leaves the contour closed.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_kind == occ_pkg::KIND_END) |=> !r_open)
        else $error("contour still open after end");

endmodule : outline_conic_to_cubic_path_stream

`default_nettype wire

FILE: verif/tb.sv
// ============================================================================
// tb
// Self-checking bench for the outline path stream with conic to cubic
// conversion. Drives outline commands on the slave side and checks every
// path beat on the master side against an in-bench prediction.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    // Coordinate width under test and the packed beat widths that follow.
    localparam int CW      = 16;
    localparam int TDATA_W = ((6*CW+7)/8)*8;
    localparam int KIND_W  = occ_pkg::KIND_W;
    localparam int OP_W    = occ_pkg::OP_W;

    // Generous cycle budget for the watchdog: a correct run stays well inside
    // it even at the worst gaps and stalls.
    localparam int LIMIT = 1_000_000;

    // Least number of random commands sent after the directed part.
    localparam int RANDOM_CMDS = 1850;

    // One outline command as it is offered on the slave side. The kind stays
    // a plain 3-bit vector so that the two unused codes can be sent as well.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic signed [CW-1:0] ax, ay, bx, by, ex, ey;
    } t_outline_cmd;

    // One path operation as it should leave the master side.
    typedef struct {
        occ_pkg::t_op op;
        logic signed [CW-1:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
        logic last;
    } t_path_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the pen position and the open-contour
    // flag, turns each accepted command into the path beats it should cause,
    // and checks beats from the master side against them in order.
    // ------------------------------------------------------------------------
    class path_scoreboard;
        logic signed [CW-1:0] pen_x, pen_y;
        logic contour_open;
        t_path_beat pending_beats[$];
        int mismatches;
        int commands_seen;
        int ignored_codes;
        int beats_checked;
        int op_count[4];

        function new();
            pen_x = '0;
            pen_y = '0;
            contour_open = 1'b0;
            mismatches = 0;
            commands_seen = 0;
            ignored_codes = 0;
            beats_checked = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        // Point plus two thirds of the way towards the control, rounded to
        // nearest with halves away from zero. A third is never exactly a half,
        // so the rounding reduces to an offset-and-truncate on the magnitude.
        function logic signed [CW-1:0] two_thirds_toward(logic signed [CW-1:0] pt,
                                                         logic signed [CW-1:0] ctrl);
            int p, c, n, q;
            p = pt;
            c = ctrl;
            n = 2 * (c - p);
            if (n >= 0) begin
                q = (n + 1) / 3;
            end else begin
                q = -((-n + 1) / 3);
            end
            return CW'(p + q);
        endfunction

        function void push_beat(occ_pkg::t_op op, logic signed [CW-1:0] p1x, p1y,
                                p2x, p2y, p3x, p3y);
            t_path_beat b;
            b.op = op;
            b.p1_x = p1x;
            b.p1_y = p1y;
            b.p2_x = p2x;
            b.p2_y = p2y;
            b.p3_x = p3x;
            b.p3_y = p3y;
            b.last = 1'b0;
            pending_beats.insert(pending_beats.size(), b);
        endfunction

        // Works out the beats of one accepted command and advances the state.
        function void note_command(t_outline_cmd c);
            int before_count;
            before_count = pending_beats.size();
            commands_seen++;
            case (c.kind)
                occ_pkg::KIND_BEGIN: begin
                    contour_open = 1'b0;
                end
                occ_pkg::KIND_MOVE: begin
                    if (contour_open) push_beat(occ_pkg::OP_CLOSE, 0, 0, 0, 0, 0, 0);
                    push_beat(occ_pkg::OP_MOVE, c.ex, c.ey, 0, 0, 0, 0);
                    pen_x = c.ex;
                    pen_y = c.ey;
                    contour_open = 1'b1;
                end
                occ_pkg::KIND_LINE: begin
                    push_beat(occ_pkg::OP_LINE, c.ex, c.ey, 0, 0, 0, 0);
                    pen_x = c.ex;
                    pen_y = c.ey;
                    contour_open = 1'b1;
                end
                occ_pkg::KIND_CONIC: begin
                    push_beat(occ_pkg::OP_CURVE,
                              two_thirds_toward(pen_x, c.ax), two_thirds_toward(pen_y, c.ay),
                              two_thirds_toward(c.ex, c.ax), two_thirds_toward(c.ey, c.ay),
                              c.ex, c.ey);
                    pen_x = c.ex;
                    pen_y = c.ey;
                end
                occ_pkg::KIND_CUBIC: begin
                    push_beat(occ_pkg::OP_CURVE, c.ax, c.ay, c.bx, c.by, c.ex, c.ey);
                    pen_x = c.ex;
                    pen_y = c.ey;
                end
                occ_pkg::KIND_END: begin
                    if (contour_open) push_beat(occ_pkg::OP_CLOSE, 0, 0, 0, 0, 0, 0);
                    contour_open = 1'b0;
                end
                default: begin
                    ignored_codes++;
                end
            endcase
            // The final beat of this command carries tlast.
            if (pending_beats.size() > before_count) begin
                pending_beats[pending_beats.size()-1].last = 1'b1;
            end
        endfunction

        function void report(string what, t_path_beat want, t_path_beat got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] %s", $realtime, what);
                $display("    want op=%0d p1=(%0d,%0d) p2=(%0d,%0d) p3=(%0d,%0d) last=%0b",
                         want.op, want.p1_x, want.p1_y, want.p2_x, want.p2_y,
                         want.p3_x, want.p3_y, want.last);
                $display("    got  op=%0d p1=(%0d,%0d) p2=(%0d,%0d) p3=(%0d,%0d) last=%0b",
                         got.op, got.p1_x, got.p1_y, got.p2_x, got.p2_y,
                         got.p3_x, got.p3_y, got.last);
            end
        endfunction

        // Checks one beat taken from the master side against the oldest one due.
        function void check_beat(logic [OP_W-1:0] op, logic [TDATA_W-1:0] data, logic last);
            t_path_beat got, want;
            got.op = occ_pkg::t_op'(op);
            got.p1_x = data[0*CW +: CW];
            got.p1_y = data[1*CW +: CW];
            got.p2_x = data[2*CW +: CW];
            got.p2_y = data[3*CW +: CW];
            got.p3_x = data[4*CW +: CW];
            got.p3_y = data[5*CW +: CW];
            got.last = last;
            beats_checked++;
            op_count[op]++;
            if (pending_beats.size() == 0) begin
                want = got;
                report("path beat with none due", want, got);
                return;
            end
            want = pending_beats.pop_front();
            if (got.op !== want.op || got.p1_x !== want.p1_x || got.p1_y !== want.p1_y ||
                got.p2_x !== want.p2_x || got.p2_y !== want.p2_y ||
                got.p3_x !== want.p3_x || got.p3_y !== want.p3_y ||
                got.last !== want.last) begin
                report("path beat mismatch", want, got);
            end
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block under test.
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    logic                 s_valid;
    logic                 s_ready;
    logic [TDATA_W-1:0]   s_data;
    logic [KIND_W-1:0]    s_user;
    logic                 m_valid;
    logic                 m_ready;
    logic [TDATA_W-1:0]   m_data;
    logic [OP_W-1:0]      m_user;
    logic                 m_last;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    outline_conic_to_cubic_path_stream #(
        .COORD_WIDTH (CW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        // ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y from bit 0 up
        .s_axis_tdata  (s_data),
        // kind
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y from bit 0 up
        .m_axis_tdata  (m_data),
        // op
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    path_scoreboard sb = new();

    // Idling is switched off for stretches so that back-to-back traffic on
    // both sides is exercised as well as the ragged case.
    logic idle_on;
    int   cycle_count;

    // Most gaps are short, a few are long enough to drain the block fully.
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Coordinates lean towards the extremes and towards small values, where
    // the rounding of the conic controls is at its most delicate.
    function automatic logic signed [CW-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return {1'b1, {(CW-1){1'b0}}};
        if (r == 1) return {1'b0, {(CW-1){1'b1}}};
        if (r < 5)  return CW'(int'($urandom_range(0, 64)) - 32);
        return CW'($urandom);
    endfunction

    function automatic t_outline_cmd make_cmd(logic [KIND_W-1:0] kind,
                                              int ax, int ay, int bx, int by,
                                              int ex, int ey);
        t_outline_cmd c;
        c.kind = kind;
        c.ax = CW'(ax);
        c.ay = CW'(ay);
        c.bx = CW'(bx);
        c.by = CW'(by);
        c.ex = CW'(ex);
        c.ey = CW'(ey);
        return c;
    endfunction

    function automatic t_outline_cmd random_cmd(logic [KIND_W-1:0] kind);
        return make_cmd(kind, pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_coord());
    endfunction

    // Offers one command from a falling edge and holds it until a rising edge
    // sees the handshake. tvalid stays high into the next command when no gap
    // is drawn, so a command can be taken on every cycle.
    task automatic send_command(t_outline_cmd c);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_user  = c.kind;
        s_data  = {c.ey, c.ex, c.by, c.bx, c.ay, c.ax};
        s_valid = 1'b1;
        do @(posedge i_clk); while (!s_ready);
        sb.note_command(c);
    endtask

    // One contour as a font would give it, with random content. Now and then
    // the begin or the end is left out, so that a move has to close the
    // previous contour itself.
    task automatic send_contour(ref int sent);
        int segs;
        if ($urandom_range(0, 1) == 1) begin
            send_command(random_cmd(occ_pkg::KIND_BEGIN));
            sent++;
        end
        send_command(random_cmd(occ_pkg::KIND_MOVE));
        sent++;
        segs = $urandom_range(1, 8);
        repeat (segs) begin
            case ($urandom_range(0, 2))
                0:       send_command(random_cmd(occ_pkg::KIND_LINE));
                1:       send_command(random_cmd(occ_pkg::KIND_CONIC));
                default: send_command(random_cmd(occ_pkg::KIND_CUBIC));
            endcase
            sent++;
        end
        if ($urandom_range(0, 9) != 0) begin
            send_command(random_cmd(occ_pkg::KIND_END));
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Master side: tready is changed only at falling edges, and each beat is
    // taken at the rising edge where tvalid and tready are both high.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        stall = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                if (idle_on && $urandom_range(0, 99) < 30) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            sb.check_beat(m_user, m_data, m_last);
        end
    end

    // Alternates stretches with and without idling on both sides.
    initial begin
        forever begin
            idle_on = 1'b1;
            repeat ($urandom_range(200, 600)) @(posedge i_clk);
            idle_on = 1'b0;
            repeat ($urandom_range(50, 200)) @(posedge i_clk);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Timed out after %0d cycles with %0d path beats still due.",
                     cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        cycle_count = 0;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_user  = '0;
        sent    = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Starts with nothing open: an end and a begin must
        // produce nothing at all.
        send_command(make_cmd(occ_pkg::KIND_END,   0, 0, 0, 0, 0, 0));
        send_command(make_cmd(occ_pkg::KIND_BEGIN, 0, 0, 0, 0, 0, 0));
        // A conic with no contour open, stretched across the whole range from
        // the origin, leaves the flag closed.
        send_command(make_cmd(occ_pkg::KIND_CONIC, 32767, -32768, 0, 0, -32768, 32767));
        send_command(make_cmd(occ_pkg::KIND_END,   0, 0, 0, 0, 0, 0));
        // A line opens a contour; the move after it must close it first.
        send_command(make_cmd(occ_pkg::KIND_LINE,  0, 0, 0, 0, 32767, -32768));
        send_command(make_cmd(occ_pkg::KIND_MOVE,  0, 0, 0, 0, -32768, -32768));
        // Conic from one corner of the range to the next, with its control at a third corner.
        send_command(make_cmd(occ_pkg::KIND_CONIC, 32767, 32767, 0, 0, 32767, -32768));
        // Cubic passed through with both control points at extremes.
        send_command(make_cmd(occ_pkg::KIND_CUBIC, -32768, 32767, 32767, -32768, 0, -1));
        // Small conics where rounding goes both ways and both signs appear.
        send_command(make_cmd(occ_pkg::KIND_CONIC, 1, 0, 0, 0, 2, 1));
        send_command(make_cmd(occ_pkg::KIND_CONIC, 3, -1, 0, 0, 4, 0));
        send_command(make_cmd(occ_pkg::KIND_CONIC, 2, 2, 0, 0, 5, -2));
        // The two unused kind codes are ignored, whatever the data says.
        send_command(make_cmd(3'd6, -1, -1, -1, -1, -1, -1));
        send_command(make_cmd(3'd7, -1, -1, -1, -1, -1, -1));
        // End closes, a second end finds nothing open.
        send_command(make_cmd(occ_pkg::KIND_END,   0, 0, 0, 0, 0, 0));
        send_command(make_cmd(occ_pkg::KIND_END,   0, 0, 0, 0, 0, 0));
        // A move with nothing open gives a lone move; a begin then drops the
        // open flag, so the following move does not close.
        send_command(make_cmd(occ_pkg::KIND_MOVE,  0, 0, 0, 0, 100, -100));
        send_command(make_cmd(occ_pkg::KIND_BEGIN, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(occ_pkg::KIND_MOVE,  0, 0, 0, 0, 0, 0));
        send_command(make_cmd(occ_pkg::KIND_CUBIC, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(occ_pkg::KIND_LINE,  0, 0, 0, 0, 0, 0));
        send_command(make_cmd(occ_pkg::KIND_CONIC, -32768, -32768, 0, 0, 32767, 32767));
        send_command(make_cmd(occ_pkg::KIND_END,   0, 0, 0, 0, 0, 0));

        // Random part: mostly well-formed contours, the rest noise made of
        // any kind, the unused codes included, with any data.
        while (sent < RANDOM_CMDS) begin
            if ($urandom_range(0, 9) < 8) begin
                send_contour(sent);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_command(random_cmd(KIND_W'($urandom_range(0, 7))));
                    sent++;
                end
            end
        end

        @(negedge i_clk);
        s_valid = 1'b0;

        // Drain, then keep watching the master side for any stray beat.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d commands (%0d with unused codes) in %0d cycles.",
                 sb.commands_seen, sb.ignored_codes, cycle_count);
        $display("Checked %0d beats: %0d move, %0d line, %0d curve, %0d close; %0d bad.",
                 sb.beats_checked, sb.op_count[occ_pkg::OP_MOVE],
                 sb.op_count[occ_pkg::OP_LINE], sb.op_count[occ_pkg::OP_CURVE],
                 sb.op_count[occ_pkg::OP_CLOSE], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
